/* rtl/assert_macros.svh */
// Assertion macros for the DC pixelation checker.
// Self-contained; pulled in by the checker file only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is low.
`define DCTPIX_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked property, also checked during reset.
`define DCTPIX_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/dctpix_pkg.sv */
// Package for the DC pixelation block: widths, codes, FSM states and the
// divider request/response structs. No dependencies.
`default_nettype none

package dctpix_pkg;

  localparam int COORD_W    = 13;  // block row / column
  localparam int N_W        = 14;  // block counts up to 8192
  localparam int PIX_W      = 16;  // region registers
  localparam int DC_W       = 16;  // DC coefficient
  localparam int BLK_SHIFT  = 3;   // 8 pixels per block
  localparam int BLK_ROUND  = 7;
  localparam int GROUPS_DEF = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_NDIV,
    ST_NWAIT,
    ST_MUL,
    ST_SEL,
    ST_RWAIT,
    ST_MEM,
    ST_DONE
  } dctpix_st_t;

  typedef struct packed {
    logic           start;
    logic [N_W-1:0] dividend;
    logic [N_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] quot;
    logic [N_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/dctpix_in_if.sv */
// Input channel: one DCT block per transaction (row, column, DC).
// Depends on dctpix_pkg.
`default_nettype none

interface dctpix_in_if
  import dctpix_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [COORD_W-1:0]      block_row;
  logic [COORD_W-1:0]      block_col;
  logic signed [DC_W-1:0]  dc_in;

  modport source (output valid, output block_row, output block_col, output dc_in,
                  input ready);
  modport sink   (input valid, input block_row, input block_col, input dc_in,
                  output ready);
endinterface

`default_nettype wire

/* rtl/dctpix_out_if.sv */
// Result channel: DC to write back and the AC clear flag.
// Depends on dctpix_pkg.
`default_nettype none

interface dctpix_out_if
  import dctpix_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DC_W-1:0]  dc_out;
  logic                    clear_ac;

  modport source (output valid, output dc_out, output clear_ac, input ready);
  modport sink   (input valid, input dc_out, input clear_ac, output ready);
endinterface

`default_nettype wire

/* rtl/dctpix_div.sv */
// Shared unsigned divider, two quotient bits per cycle (restoring).
// Depends on dctpix_pkg (N_W, div_req_t, div_rsp_t).
`default_nettype none

module dctpix_div
  import dctpix_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEPS = (N_W + 1) / 2;
  localparam int DW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DW-1:0]  dvd_r, dvd_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [N_W-1:0] dvs_r;
  logic [N_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r;
  logic           done_r;

  logic [N_W:0]   t1, t2, d_ext;
  logic           q1, q2;
  logic [N_W:0]   r1, r2;

  // Two dependent restoring steps per cycle.
  always_comb begin
    d_ext   = {1'b0, dvs_r};
    t1      = {rem_r, dvd_r[DW-1]};
    q1      = (t1 >= d_ext);
    r1      = q1 ? (t1 - d_ext) : t1;
    t2      = {r1[N_W-1:0], dvd_r[DW-2]};
    q2      = (t2 >= d_ext);
    r2      = q2 ? (t2 - d_ext) : t2;
    rem_nxt = r2[N_W-1:0];
    dvd_nxt = {dvd_r[DW-3:0], 2'b00};
    quo_nxt = {quo_r[DW-3:0], q1, q2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= CW'(STEPS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= DW'(req.dividend);
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r[N_W-1:0];
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

/* rtl/dct_dc_pixelation_top.sv */
// Top level of the DC pixelation block: config registers, sequencer,
// group DC memory and output register. Depends on dctpix_pkg, the two
// channel interfaces and dctpix_div.
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+-------------
//   in_ch    | in  | block_row, block_col, dc_in      | valid/ready
//   out_ch   | out | dc_out, clear_ac                 | valid/ready
//   cfg_*    | in  | cfg_idx, cfg_wdata               | cfg_we only
//
// A block outside the region is loaded into the output register after
// the setup state that follows its acceptance. A block inside goes through
// setup, then per axis: start the two-bit-per-cycle divider for n / GROUPS,
// wait on it, multiply, then select, which starts a second division of the
// position by the group size unless that size is zero, and wait on it; after
// the column axis come the memory access and the load. in_ch.ready is high
// only while the sequencer is idle. The output register holds its transaction
// until out_ch.ready; the sequencer waits in its last state while that
// register is full and out_ch.ready is low. Reset is synchronous, active low:
// it clears the sequencer, the config registers, the output valid and the
// memory's per-entry valid bits, so an unwritten entry reads as zero.
`default_nettype none

module dct_dc_pixelation_top
  import dctpix_pkg::*;
#(
  parameter int GROUPS = GROUPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dctpix_in_if.sink                 in_ch,
  dctpix_out_if.source              out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [PIX_W-1:0]     cfg_wdata
);

  localparam int GW    = $clog2(GROUPS);
  localparam int GFW   = N_W + 1;
  localparam int GMASK = (GROUPS - 1) | 63;

  // Config registers
  logic [PIX_W-1:0] left_r, right_r, top_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_LEFT:   left_r   <= cfg_wdata;
        REG_RIGHT:  right_r  <= cfg_wdata;
        REG_TOP:    top_r    <= cfg_wdata;
        REG_BOTTOM: bottom_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Sequencer and datapath registers
  dctpix_st_t              st_r, st_nxt;
  logic [COORD_W-1:0]      row_r, row_nxt, col_r, col_nxt;
  logic signed [DC_W-1:0]  dc_r, dc_nxt;
  logic                    axis_r, axis_nxt;       // 0 row, 1 column
  logic                    inside_r, inside_nxt;
  logic [N_W-1:0]          nrow_r, nrow_nxt, ncol_r, ncol_nxt;
  logic [COORD_W-1:0]      rrel_r, rrel_nxt, crel_r, crel_nxt;
  logic [N_W-2:0]          per_r, per_nxt;
  logic [GW-1:0]           nxl_r, nxl_nxt;
  logic [N_W-1:0]          merged_r, merged_nxt;
  logic [GW-1:0]           base_r, base_nxt;
  logic                    frow_r, frow_nxt, fcol_r, fcol_nxt;
  logic [GW-1:0]           g_r, g_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [DC_W-1:0]  odc_r, odc_nxt;
  logic                    oclr_r, oclr_nxt;

  // Memory read port
  logic signed [DC_W-1:0]  mem [GROUPS];
  logic [GROUPS-1:0]       vld_r;
  logic signed [DC_W-1:0]  rd_r;
  logic                    rdv_r;

  div_req_t dreq;
  div_rsp_t drsp;

  dctpix_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Region bounds in block units
  logic [N_W-1:0]      scol, ecol, srow, erow;
  logic [PIX_W:0]      rsum, bsum;
  logic                in_col, in_row;
  logic [N_W-1:0]      n_cur;
  logic [COORD_W-1:0]  rel_cur;
  logic [N_W-1:0]      per_xl;
  logic [N_W+GW-1:0]   prod;
  logic [N_W-1:0]      rel_ext;
  logic [GFW-1:0]      g_full, g_m;
  logic [GW-1:0]       g_sel;
  logic                first_q;

  always_comb begin
    rsum    = {1'b0, right_r}  + (PIX_W+1)'(BLK_ROUND);
    bsum    = {1'b0, bottom_r} + (PIX_W+1)'(BLK_ROUND);
    scol    = {1'b0, left_r[PIX_W-1:BLK_SHIFT]};
    srow    = {1'b0, top_r[PIX_W-1:BLK_SHIFT]};
    ecol    = rsum[PIX_W:BLK_SHIFT];
    erow    = bsum[PIX_W:BLK_SHIFT];
    in_col  = (ecol > scol) && ({1'b0, col_r} >= scol) && ({1'b0, col_r} < ecol);
    in_row  = (erow > srow) && ({1'b0, row_r} >= srow) && ({1'b0, row_r} < erow);
    n_cur   = axis_r ? ncol_r : nrow_r;
    rel_cur = axis_r ? crel_r : rrel_r;
    rel_ext = {1'b0, rel_cur};
    per_xl  = {1'b0, per_r} + N_W'(1);
    prod    = per_xl * (N_W+GW)'(nxl_r);
    // Group index: offset plus quotient, masked and clamped to the memory
    g_full  = GFW'(base_r) + GFW'(drsp.quot);
    g_m     = g_full & GFW'(GMASK);
    g_sel   = (g_m >= GFW'(GROUPS)) ? GW'(GROUPS - 1) : g_m[GW-1:0];
    first_q = (drsp.rem == '0);
  end

  always_comb begin
    st_nxt     = st_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    dc_nxt     = dc_r;
    axis_nxt   = axis_r;
    inside_nxt = inside_r;
    nrow_nxt   = nrow_r;
    ncol_nxt   = ncol_r;
    rrel_nxt   = rrel_r;
    crel_nxt   = crel_r;
    per_nxt    = per_r;
    nxl_nxt    = nxl_r;
    merged_nxt = merged_r;
    base_nxt   = base_r;
    frow_nxt   = frow_r;
    fcol_nxt   = fcol_r;
    g_nxt      = g_r;
    ov_nxt     = ov_r && !out_ch.ready;
    odc_nxt    = odc_r;
    oclr_nxt   = oclr_r;
    dreq       = '0;

    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          row_nxt = in_ch.block_row;
          col_nxt = in_ch.block_col;
          dc_nxt  = in_ch.dc_in;
          st_nxt  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        inside_nxt = in_col && in_row;
        ncol_nxt   = ecol - scol;
        nrow_nxt   = erow - srow;
        crel_nxt   = col_r - scol[COORD_W-1:0];
        rrel_nxt   = row_r - srow[COORD_W-1:0];
        axis_nxt   = 1'b0;
        st_nxt     = (in_col && in_row) ? ST_NDIV : ST_DONE;
      end
      ST_NDIV: begin
        // Split the axis: per = n / GROUPS, n_xl = n % GROUPS
        dreq.start    = 1'b1;
        dreq.dividend = n_cur;
        dreq.divisor  = N_W'(GROUPS);
        st_nxt        = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (drsp.done) begin
          per_nxt = drsp.quot[N_W-2:0];
          nxl_nxt = drsp.rem[GW-1:0];
          st_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        merged_nxt = prod[N_W-1:0];
        st_nxt     = ST_SEL;
      end
      ST_SEL: begin
        if (rel_ext < merged_r) begin
          dreq.start    = 1'b1;
          dreq.dividend = rel_ext;
          dreq.divisor  = per_xl;
          base_nxt      = '0;
          st_nxt        = ST_RWAIT;
        end else if (per_r != '0) begin
          dreq.start    = 1'b1;
          dreq.dividend = rel_ext - merged_r;
          dreq.divisor  = {1'b0, per_r};
          base_nxt      = nxl_r;
          st_nxt        = ST_RWAIT;
        end else begin
          // Empty groups: index zero, never a first block
          if (axis_r) begin
            fcol_nxt = 1'b0;
            g_nxt    = '0;
            st_nxt   = ST_MEM;
          end else begin
            frow_nxt = 1'b0;
            axis_nxt = 1'b1;
            st_nxt   = ST_NDIV;
          end
        end
      end
      ST_RWAIT: begin
        if (drsp.done) begin
          if (axis_r) begin
            fcol_nxt = first_q;
            g_nxt    = g_sel;
            st_nxt   = ST_MEM;
          end else begin
            frow_nxt = first_q;
            axis_nxt = 1'b1;
            st_nxt   = ST_NDIV;
          end
        end
      end
      ST_MEM: begin
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          if (!inside_r) begin
            odc_nxt  = dc_r;
            oclr_nxt = 1'b0;
          end else begin
            odc_nxt  = (frow_r && fcol_r) ? dc_r : (rdv_r ? rd_r : '0);
            oclr_nxt = 1'b1;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    dc_r     <= dc_nxt;
    axis_r   <= axis_nxt;
    inside_r <= inside_nxt;
    nrow_r   <= nrow_nxt;
    ncol_r   <= ncol_nxt;
    rrel_r   <= rrel_nxt;
    crel_r   <= crel_nxt;
    per_r    <= per_nxt;
    nxl_r    <= nxl_nxt;
    merged_r <= merged_nxt;
    base_r   <= base_nxt;
    frow_r   <= frow_nxt;
    fcol_r   <= fcol_nxt;
    g_r      <= g_nxt;
    odc_r    <= odc_nxt;
    oclr_r   <= oclr_nxt;
  end

  // Group DC memory: registered read; the first block of a group writes
  always_ff @(posedge clk) begin
    if (st_r == ST_MEM) begin
      rd_r <= mem[g_r];
      if (frow_r && fcol_r) begin
        mem[g_r] <= dc_r;
      end
    end
  end

  // Valid bits: an entry not yet written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else if (st_r == ST_MEM) begin
      rdv_r <= vld_r[g_r];
      if (frow_r && fcol_r) begin
        vld_r[g_r] <= 1'b1;
      end
    end
  end

  assign in_ch.ready     = (st_r == ST_IDLE);
  assign out_ch.valid    = ov_r;
  assign out_ch.dc_out   = odc_r;
  assign out_ch.clear_ac = oclr_r;

endmodule

`default_nettype wire

/* rtl/dctpix_chk.sv */
// Port-level checker for dct_dc_pixelation_top and its bind statement.
// Depends on dctpix_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dctpix_chk
  import dctpix_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic signed [DC_W-1:0] out_dc,
  input wire logic                   out_clr
);

  // Hold a stalled result transaction
  `DCTPIX_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out valid dropped")
  `DCTPIX_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_dc) && $stable(out_clr), "out payload moved")
  // One block in flight: busy right after an accepted transaction
  `DCTPIX_ASSERT(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "accepted while busy")
  // Reset leaves the block idle and empty
  `DCTPIX_ASSERT_RST(a_reset, clk, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind dct_dc_pixelation_top dctpix_chk u_dctpix_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_dc    (out_ch.dc_out),
  .out_clr   (out_ch.clear_ac)
);

`default_nettype wire
